### src/shkt_pkg.sv
`timescale 1ns / 1ps

package shkt_pkg;

  // Default geometry of the table
  localparam int BUCKET_COUNT_DEF = 1024;
  localparam int BUCKET_WAYS_DEF  = 4;

  // Width of the live-entry count in the result word
  localparam int LIVE_W = 13;

  // Hash multipliers for the x and z coordinates
  localparam logic [31:0] HASH_MUL_X = 32'd73856093;
  localparam logic [31:0] HASH_MUL_Z = 32'd19349663;

  // Action codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_z;
    logic [15:0]        handle_in;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              found;
    logic [15:0]       handle_out;
    logic [LIVE_W-1:0] live_count;
  } rsp_t;

  // One stored way of a bucket
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] z;
    logic [15:0] handle;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;
    logic load_in;
    logic hash;
    logic read;
    logic commit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

### src/shkt_ctrl.sv
`timescale 1ns / 1ps

module shkt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  shkt_pkg::sts_t  sts,
  output shkt_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_EXEC
  } state_t;

  state_t state;

  // Advance the sequence: clear sweep, then hash, row read, execute per word
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      case (state)
        S_CLEAR: if (sts.clr_last) state <= S_IDLE;
        S_IDLE:  if (req_valid) state <= S_HASH;
        S_HASH:  state <= S_READ;
        S_READ:  state <= S_EXEC;
        S_EXEC:  if (sts.out_free) state <= S_IDLE;
        default: state <= S_CLEAR;
      endcase
    end
  end

  // Decode commands from the state
  always_comb begin
    cmd         = '0;
    cmd.clear   = (state == S_CLEAR);
    cmd.load_in = (state == S_IDLE) && req_valid;
    cmd.hash    = (state == S_HASH);
    cmd.read    = (state == S_READ);
    cmd.commit  = (state == S_EXEC) && sts.out_free;
  end

  assign req_stall = (state != S_IDLE);

endmodule

### src/shkt_datapath.sv
`timescale 1ns / 1ps

module shkt_datapath #(
  parameter int BUCKET_COUNT = shkt_pkg::BUCKET_COUNT_DEF,
  parameter int BUCKET_WAYS  = shkt_pkg::BUCKET_WAYS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  shkt_pkg::req_t  req,
  input  logic            rsp_stall,
  output logic            rsp_valid,
  output shkt_pkg::rsp_t  rsp,
  input  shkt_pkg::cmd_t  cmd,
  output shkt_pkg::sts_t  sts
);

  localparam int IDX_W  = $clog2(BUCKET_COUNT);
  localparam int FILL_W = $clog2(BUCKET_WAYS + 1);
  localparam int WAY_W  = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
  localparam int LIVE_W = shkt_pkg::LIVE_W;

  shkt_pkg::req_t req_q;
  logic [IDX_W-1:0] hx;
  logic [IDX_W-1:0] hz;
  logic [IDX_W-1:0] bucket;
  logic [IDX_W-1:0] clr_idx;

  // Bucket rows and fill counts
  shkt_pkg::entry_t [BUCKET_WAYS-1:0] row_mem [BUCKET_COUNT];
  logic [FILL_W-1:0] fill_mem [BUCKET_COUNT];

  shkt_pkg::entry_t [BUCKET_WAYS-1:0] row_q;
  shkt_pkg::entry_t [BUCKET_WAYS-1:0] row_new;
  logic [FILL_W-1:0] fill_q;
  logic [FILL_W-1:0] fill_new;
  logic [LIVE_W-1:0] live;
  logic [LIVE_W-1:0] live_next;

  logic             hit;
  logic [WAY_W-1:0] hit_way;
  logic             is_full;
  logic             row_we;
  logic             fill_we;
  shkt_pkg::rsp_t   rsp_new;

  // Hash: only the low index bits of each product are needed
  assign hx = IDX_W'(req_q.coord_x[IDX_W-1:0] * shkt_pkg::HASH_MUL_X[IDX_W-1:0]);
  assign hz = IDX_W'(req_q.coord_z[IDX_W-1:0] * shkt_pkg::HASH_MUL_Z[IDX_W-1:0]);

  // Capture the word and its bucket
  always_ff @(posedge clk) begin
    if (cmd.load_in) req_q <= req;
    if (cmd.hash) bucket <= hx ^ hz;
  end

  // Step the clear sweep over the fill counts
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clear) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  // Read the bucket row and its fill count
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      row_q  <= row_mem[bucket];
      fill_q <= fill_mem[bucket];
    end
  end

  // Write back the row
  always_ff @(posedge clk) begin
    if (cmd.commit && row_we) row_mem[bucket] <= row_new;
  end

  // Write back the fill count, or clear it during the sweep
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      fill_mem[clr_idx] <= '0;
    end else if (cmd.commit && fill_we) begin
      fill_mem[bucket] <= fill_new;
    end
  end

  // Find the newest live way that matches the key
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = 0; w < BUCKET_WAYS; w++) begin
      if ((FILL_W'(w) < fill_q) &&
          (row_q[w].x == $unsigned(req_q.coord_x)) &&
          (row_q[w].z == $unsigned(req_q.coord_z))) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  assign is_full = (fill_q == FILL_W'(BUCKET_WAYS));

  // Build the new row: append on insert, close the gap on remove
  always_comb begin
    row_new = row_q;
    case (req_q.action)
      shkt_pkg::ACT_INSERT: begin
        for (int w = 0; w < BUCKET_WAYS; w++) begin
          if (FILL_W'(w) == fill_q) begin
            row_new[w].x      = $unsigned(req_q.coord_x);
            row_new[w].z      = $unsigned(req_q.coord_z);
            row_new[w].handle = req_q.handle_in;
          end
        end
      end
      shkt_pkg::ACT_REMOVE: begin
        for (int w = 0; w < BUCKET_WAYS - 1; w++) begin
          if (WAY_W'(w) >= hit_way) row_new[w] = row_q[w + 1];
        end
      end
      default: ;
    endcase
  end

  // Form the result and the write enables
  always_comb begin
    rsp_new   = '0;
    rsp_new.status = shkt_pkg::ST_OK;
    fill_new  = fill_q;
    live_next = live;
    row_we    = 1'b0;
    fill_we   = 1'b0;
    case (req_q.action)
      shkt_pkg::ACT_INSERT: begin
        if (is_full) begin
          rsp_new.status = shkt_pkg::ST_FULL;
        end else begin
          row_we    = 1'b1;
          fill_we   = 1'b1;
          fill_new  = FILL_W'(fill_q + 1'b1);
          live_next = LIVE_W'(live + 1'b1);
        end
      end
      shkt_pkg::ACT_REMOVE: begin
        if (!hit) begin
          rsp_new.status = shkt_pkg::ST_MISS;
        end else begin
          rsp_new.found      = 1'b1;
          rsp_new.handle_out = row_q[hit_way].handle;
          row_we    = 1'b1;
          fill_we   = 1'b1;
          fill_new  = FILL_W'(fill_q - 1'b1);
          live_next = LIVE_W'(live - 1'b1);
        end
      end
      shkt_pkg::ACT_LOOKUP: begin
        if (!hit) begin
          rsp_new.status = shkt_pkg::ST_MISS;
        end else begin
          rsp_new.found      = 1'b1;
          rsp_new.handle_out = row_q[hit_way].handle;
        end
      end
      default: ;
    endcase
    rsp_new.live_count = live_next;
  end

  // Hold the live count
  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
    end else if (cmd.commit) begin
      live <= live_next;
    end
  end

  // Output register: load on commit, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) rsp <= rsp_new;
  end

  assign sts.out_free = !rsp_valid || !rsp_stall;
  assign sts.clr_last = (clr_idx == '1);

endmodule

### src/spatial_hash_key_table.sv
// Request path: the controller steps through accept, hash, bucket row read, then compare
// with write-back into the output register; then the response word is offered. A new
// request word is taken only after the last one has been written into the output register,
// so the execute state, and with it the next accept, waits while the response stalls.
// Reset: synchronous, active high; a sweep then clears
// the bucket fill counts, with req_stall high until it ends.
`timescale 1ns / 1ps

module spatial_hash_key_table #(
  parameter int BUCKET_COUNT = shkt_pkg::BUCKET_COUNT_DEF,
  parameter int BUCKET_WAYS  = shkt_pkg::BUCKET_WAYS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  shkt_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output shkt_pkg::rsp_t  rsp
);

  shkt_pkg::cmd_t cmd;
  shkt_pkg::sts_t sts;

  shkt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  shkt_datapath #(
    .BUCKET_COUNT (BUCKET_COUNT),
    .BUCKET_WAYS  (BUCKET_WAYS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

### src/shkt_checker.sv
`timescale 1ns / 1ps

module shkt_checker (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_stall,
  input shkt_pkg::req_t  req,
  input logic            rsp_valid,
  input logic            rsp_stall,
  input shkt_pkg::rsp_t  rsp
);

  // A stalled response word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response word changed while stalled");

  // After reset the table is busy clearing and shows no response
  a_reset_busy: assert property (@(posedge clk)
    rst |=> req_stall && !rsp_valid)
    else $error("table not busy after reset");

  // A new response only follows a cycle in which a request was in flight
  a_rsp_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("response appeared with no request in flight");

  // A miss or a refused insert carries no handle
  a_miss_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != shkt_pkg::ST_OK) |-> !rsp.found && (rsp.handle_out == '0))
    else $error("failed word reports a handle");

endmodule

bind spatial_hash_key_table shkt_checker u_shkt_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

### verif/shkt_table_checker.sv
`timescale 1ns / 1ps

module shkt_table_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_stall,
  input  shkt_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  shkt_pkg::rsp_t rsp,
  output int             errors,
  output int             pending
);
  import shkt_pkg::*;

  localparam int BUCKETS = BUCKET_COUNT_DEF;
  localparam int WAYS    = BUCKET_WAYS_DEF;

  // Shadow table: ways of each bucket ordered oldest to newest
  entry_t      bucket_slot  [BUCKETS][WAYS];
  int unsigned bucket_depth [BUCKETS];
  int unsigned live_entries;
  rsp_t        rsp_due [$];
  int          mismatch_count = 0;

  function automatic int unsigned bucket_index(logic [31:0] x, logic [31:0] z);
    logic [31:0] h;
    h = (x * HASH_MUL_X) ^ (z * HASH_MUL_Z);
    return h % BUCKETS;
  endfunction

  // Apply one request word to the shadow table and return the response it owes
  function automatic rsp_t table_apply(req_t w);
    int unsigned b;
    int          hit;
    rsp_t        r;
    b   = bucket_index(w.coord_x, w.coord_z);
    hit = -1;
    r   = '0;
    case (w.action)
      ACT_INSERT: begin
        if (bucket_depth[b] >= WAYS) begin
          r.status = ST_FULL;
        end else begin
          bucket_slot[b][bucket_depth[b]] = '{x: w.coord_x, z: w.coord_z, handle: w.handle_in};
          bucket_depth[b]++;
          live_entries++;
        end
      end
      ACT_REMOVE, ACT_LOOKUP: begin
        // the last match in oldest-to-newest order is the newest one
        for (int k = 0; k < int'(bucket_depth[b]); k++) begin
          if (bucket_slot[b][k].x == w.coord_x && bucket_slot[b][k].z == w.coord_z) begin
            hit = k;
          end
        end
        if (hit < 0) begin
          r.status = ST_MISS;
        end else begin
          r.found      = 1'b1;
          r.handle_out = bucket_slot[b][hit].handle;
          if (w.action == ACT_REMOVE) begin
            // close the gap, keep the order of the rest
            for (int k = hit; k + 1 < int'(bucket_depth[b]); k++) begin
              bucket_slot[b][k] = bucket_slot[b][k + 1];
            end
            bucket_depth[b]--;
            live_entries--;
          end
        end
      end
      default: begin
        // unused action code: nothing changes
      end
    endcase
    r.live_count = LIVE_W'(live_entries);
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 50) begin
      $display("%0t: response mismatch on %s: got %0h, expected %0h", $time, field, got, want);
    end
    mismatch_count++;
  endtask

  // Predict on accepted requests, compare accepted responses with the oldest due
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int b = 0; b < BUCKETS; b++) bucket_depth[b] = 0;
      live_entries = 0;
      rsp_due.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (rsp_due.size() == 0) begin
          report_mismatch("unexpected word", rsp, '0);
        end else begin
          want = rsp_due.pop_front();
          if (rsp.status !== want.status) report_mismatch("status", rsp.status, want.status);
          if (rsp.found !== want.found) report_mismatch("found", rsp.found, want.found);
          if (rsp.handle_out !== want.handle_out) begin
            report_mismatch("handle_out", rsp.handle_out, want.handle_out);
          end
          if (rsp.live_count !== want.live_count) begin
            report_mismatch("live_count", rsp.live_count, want.live_count);
          end
        end
      end
      if (req_valid && !req_stall) rsp_due.push_back(table_apply(req));
    end
    pending <= rsp_due.size();
    errors  <= mismatch_count;
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import shkt_pkg::*;

  localparam logic [1:0]  ACT_UNUSED  = 2'd3;
  localparam logic [31:0] COORD_MIN   = 32'h8000_0000;
  localparam logic [31:0] COORD_MAX   = 32'h7fff_ffff;
  localparam int          RANDOM_OPS  = 1700;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          HOT_GROUPS  = 8;
  localparam int          GROUP_KEYS  = 6;
  localparam int          LOOSE_KEYS  = 16;
  localparam int          HOT_KEYS    = HOT_GROUPS * GROUP_KEYS;
  localparam int          POOL_KEYS   = HOT_KEYS + LOOSE_KEYS;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_SOLID} stall_mode_e;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req       = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;
  int          errors;
  int          pending;

  logic [31:0] pool_x [POOL_KEYS];
  logic [31:0] pool_z [POOL_KEYS];
  int          burst_left  = 0;
  int          cycle_count = 0;
  stall_mode_e stall_mode  = STALL_NONE;
  int          mode_left   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  spatial_hash_key_table dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  shkt_table_checker table_chk (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending)
  );

  // Stall the response side in modes of random length
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left  = (stall_mode == STALL_SOLID) ? $urandom_range(1, 12)
                                                 : $urandom_range(20, 150);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:  rsp_stall <= 1'b0;
        STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
        default:     rsp_stall <= 1'b1;
      endcase
    end
  end

  function automatic req_t make_word(logic [1:0] act, logic [31:0] x, logic [31:0] z,
                                     logic [15:0] h);
    req_t w;
    w.action    = act;
    w.coord_x   = x;
    w.coord_z   = z;
    w.handle_in = h;
    return w;
  endfunction

  // Mostly keys from the pool so buckets fill up and lookups hit
  function automatic req_t random_word(int insert_pct);
    int   roll;
    int   pick;
    int   k;
    req_t w;
    roll        = $urandom_range(0, 99);
    pick        = $urandom_range(0, 99);
    w.handle_in = 16'($urandom);
    if (roll < 5) w.action = ACT_UNUSED;
    else if (roll < 5 + insert_pct) w.action = ACT_INSERT;
    else if (roll < 5 + insert_pct + (95 - insert_pct) / 2) w.action = ACT_REMOVE;
    else w.action = ACT_LOOKUP;
    if (pick < 90) begin
      k = (pick < 75) ? $urandom_range(0, HOT_KEYS - 1) : $urandom_range(HOT_KEYS, POOL_KEYS - 1);
      w.coord_x = pool_x[k];
      w.coord_z = pool_z[k];
    end else begin
      w.coord_x = $urandom;
      w.coord_z = $urandom;
    end
    return w;
  endfunction

  // Hold a word until it is taken; open a random gap when the burst runs out
  task automatic send_word(input req_t w);
    int gap;
    if (burst_left <= 0) begin
      gap        = $urandom_range(1, 10);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    burst_left--;
  endtask

  // Drop valid and hold off until every due response has come back
  task automatic wait_drained;
    req_valid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int          sent_ops;
    int          insert_pct;
    logic [31:0] bx;
    logic [31:0] bz;
    req_t        w;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Keys of one group differ by multiples of the bucket count: same bucket
    for (int g = 0; g < HOT_GROUPS; g++) begin
      bx = $urandom;
      bz = $urandom;
      for (int k = 0; k < GROUP_KEYS; k++) begin
        pool_x[g * GROUP_KEYS + k] = bx + ($urandom << $clog2(BUCKET_COUNT_DEF));
        pool_z[g * GROUP_KEYS + k] = bz + ($urandom << $clog2(BUCKET_COUNT_DEF));
      end
    end
    for (int k = HOT_KEYS; k < POOL_KEYS; k++) begin
      pool_x[k] = $urandom;
      pool_z[k] = $urandom;
    end

    // Empty table misses, coordinate extremes, duplicates, unused action
    send_word(make_word(ACT_LOOKUP, '0, '0, 16'hffff));
    send_word(make_word(ACT_REMOVE, '0, '0, 16'h0000));
    send_word(make_word(ACT_INSERT, '0, '0, 16'h0000));
    send_word(make_word(ACT_INSERT, COORD_MIN, COORD_MAX, 16'hffff));
    send_word(make_word(ACT_INSERT, COORD_MAX, COORD_MIN, 16'h5a5a));
    send_word(make_word(ACT_INSERT, '1, '1, 16'ha5a5));
    send_word(make_word(ACT_LOOKUP, COORD_MIN, COORD_MAX, 16'h0000));
    send_word(make_word(ACT_INSERT, '0, '0, 16'h1234));
    send_word(make_word(ACT_LOOKUP, '0, '0, 16'h0000));
    send_word(make_word(ACT_REMOVE, '0, '0, 16'h0000));
    send_word(make_word(ACT_LOOKUP, '0, '0, 16'h0000));
    send_word(make_word(ACT_UNUSED, $urandom, $urandom, 16'($urandom)));

    // Overfill one bucket, then remove from the middle and refill
    for (int k = 0; k < BUCKET_WAYS_DEF + 1; k++) begin
      send_word(make_word(ACT_INSERT, pool_x[k], pool_z[k], 16'(k + 1)));
    end
    send_word(make_word(ACT_REMOVE, pool_x[1], pool_z[1], 16'h0000));
    send_word(make_word(ACT_LOOKUP, pool_x[3], pool_z[3], 16'h0000));
    send_word(make_word(ACT_INSERT, pool_x[4], pool_z[4], 16'h0044));
    send_word(make_word(ACT_LOOKUP, pool_x[1], pool_z[1], 16'h0000));
    wait_drained();

    // Random traffic, alternating between filling and draining phases
    sent_ops = 0;
    while (sent_ops < RANDOM_OPS) begin
      insert_pct = ((sent_ops / 200) % 2 == 0) ? 55 : 20;
      w = random_word(insert_pct);
      send_word(w);
      if (w.action != ACT_UNUSED) begin
        sent_ops++;
        if (sent_ops == RANDOM_OPS / 2) wait_drained();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("spatial_hash_key_table regression: pass");
    end else begin
      $display("spatial_hash_key_table regression: fail");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("spatial_hash_key_table regression: fail");
    $finish;
  end

endmodule
